FILE: src/gbp_pkg.sv
package gbp_pkg;

   localparam int PW = 13;
   localparam int SW = 16;
   localparam int TW = 12;
   localparam int NW = 17;

   typedef struct packed {
      logic [PW-1:0] proc_count;
      logic [SW-1:0] grid_x_segments;
      logic [SW-1:0] grid_y_segments;
      logic [TW-1:0] tile_x;
      logic [TW-1:0] tile_y;
   } req_type;

   typedef struct packed {
      logic          found;
      logic [PW-1:0] parts_x;
      logic [PW-1:0] parts_y;
      logic          tile_valid;
      logic [SW-1:0] x_first_node;
      logic [SW-1:0] x_last_node;
      logic [NW-1:0] x_nodes_total;
      logic [NW-1:0] x_nodes_owned;
      logic [SW-1:0] y_first_node;
      logic [SW-1:0] y_last_node;
      logic [NW-1:0] y_nodes_total;
      logic [NW-1:0] y_nodes_owned;
   } rsp_type;

   // divider operand selects
   typedef enum logic [2:0] {
      DOP_P_T  = 3'd0,
      DOP_M_R  = 3'd1,
      DOP_N_C  = 3'd2,
      DOP_M_Q  = 3'd3,
      DOP_N_T  = 3'd4
   } dop_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    div_start;
      dop_type div_op;
      logic    take_pt;
      logic    take_a;
      logic    take_b;
      logic    next_t;
      logic    set_swap;
      logic    clr_swap;
      logic    fail;
      logic    finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic bad_input;
      logic t_over;
      logic divides;
      logic same;
      logic swapped;
      logic pair_ok;
   } sts_type;

endpackage

FILE: src/gbp_if.sv
interface gbp_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/grid_block_partition_planner.sv
// grid block partition planner
// req channel: one word holds proc_count, grid_x_segments, grid_y_segments,
// tile_x and tile_y. rsp channel: one word per request with the split found,
// the tile's node ranges and counts, or zeros where no split fits.
// one request is handled at a time: a new word is taken only once the last
// result has left. the search steps the trial divisor t upward while t*t
// does not exceed proc_count; each step runs one division of the process
// count by t, and each divisor pair tried costs two more divisions (x and
// y side lengths). all divisions share one bit-serial divider, and a final
// division gives the y ranges once a split is accepted. out-of-range inputs
// are answered without any division: the check state goes straight to the
// output state.
// the result is held in a register with rsp_valid high until rsp_ready;
// while the receiver stalls req_ready stays low.
// reset (synchronous, active high) returns the block to idle, ready for a
// word, with no result pending.
module grid_block_partition_planner #(
   parameter int MAX_PROCS    = 4096,
   parameter int MAX_SEGMENTS = 65535
) (
   input logic clock,
   input logic reset,
   gbp_if.sink   req,
   gbp_if.source rsp
);
   gbp_pkg::cmd_type cmd;
   gbp_pkg::sts_type sts;
   gbp_pkg::rsp_type res;
   gbp_pkg::req_type rq;

   assign rq = req.data;

   gbp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd)
   );

   gbp_datapath #(.MAX_PROCS(MAX_PROCS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock(clock), .reset(reset), .req_word(rq), .cmd(cmd), .sts(sts),
      .result(res)
   );

   assign rsp.data = res;
endmodule

FILE: src/gbp_div.sv
module gbp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] num,
   input  logic [16:0] den,
   output logic        done,
   output logic [16:0] quo,
   output logic [16:0] rem
);
   logic [16:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [17:0] trial;

   // restoring, one quotient bit a cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[16]} - {1'b0, d_ff};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = 5'd17; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            r_in = trial[16:0]; q_in = {q_ff[15:0], 1'b1};
         end else begin
            r_in = {r_ff[15:0], q_ff[16]}; q_in = {q_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule

FILE: src/gbp_datapath.sv
module gbp_datapath #(
   parameter int MAX_PROCS    = 4096,
   parameter int MAX_SEGMENTS = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  gbp_pkg::req_type  req_word,
   input  gbp_pkg::cmd_type  cmd,
   output gbp_pkg::sts_type  sts,
   output gbp_pkg::rsp_type  result
);
   localparam int PW = gbp_pkg::PW;
   localparam int SW = gbp_pkg::SW;
   localparam int NW = gbp_pkg::NW;

   gbp_pkg::req_type rq_ff;
   logic [PW-1:0] t_ff, other_ff, r_ff, c_ff;
   logic [16:0]   qa_ff, ra_ff;
   logic          swap_ff;
   logic [16:0]   num, den, quo, rem;
   logic          div_done;
   logic [25:0]   tt;

   always_comb begin
      num = '0; den = 17'd1;
      unique case (cmd.div_op)
         gbp_pkg::DOP_P_T: begin num = 17'(rq_ff.proc_count); den = 17'(t_ff); end
         gbp_pkg::DOP_M_R: begin num = 17'(rq_ff.grid_x_segments); den = 17'(r_ff); end
         gbp_pkg::DOP_N_C: begin num = 17'(rq_ff.grid_y_segments); den = 17'(c_ff); end
         gbp_pkg::DOP_M_Q: begin num = 17'(rq_ff.grid_x_segments); den = 17'(r_ff); end
         gbp_pkg::DOP_N_T: begin num = 17'(rq_ff.grid_y_segments); den = 17'(c_ff); end
         default: begin num = '0; den = 17'd1; end
      endcase
   end

   gbp_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .num(num), .den(den),
      .done(div_done), .quo(quo), .rem(rem)
   );

   // pair test from two quotient/remainder results
   logic [17:0] lo_x, hi_x, lo_y, hi_y;
   always_comb begin
      lo_x = 18'(qa_ff);
      hi_x = 18'(qa_ff) + 18'(ra_ff != '0);
      lo_y = 18'(quo);
      hi_y = 18'(quo) + 18'(rem != '0);
   end

   // axis range from base/rem of one axis
   function automatic logic [4*NW-1:0] axis(input logic [SW-1:0] segs,
      input logic [PW-1:0] parts, input logic [gbp_pkg::TW-1:0] k,
      input logic [16:0] base, input logic [16:0] rm);
      logic [NW-1:0] start, size, hi, kk, mn;
      logic          lt;
      kk    = NW'(k);
      lt    = 17'(k) < rm;
      mn    = lt ? kk : rm;
      start = NW'(kk * base) + mn;
      size  = base + NW'(lt);
      hi    = (13'(k) + 13'd1 < parts) ? start + size + 17'd1 : NW'(segs);
      axis  = {start, hi, hi - start + 17'd1, size + 17'd1 - NW'(k != '0)};
   endfunction

   gbp_pkg::rsp_type res_ff, res_in;
   logic [4*NW-1:0] ax;
   logic            tin;
   always_comb begin
      res_in = res_ff;
      tin = (13'(rq_ff.tile_x) < r_ff) && (13'(rq_ff.tile_y) < c_ff);
      ax = '0;
      if (cmd.fail) res_in = '0;
      if (cmd.take_a) begin
         // x axis stage: quotient of M by R
         res_in = '0;
         res_in.found = 1'b1; res_in.parts_x = r_ff; res_in.parts_y = c_ff;
         res_in.tile_valid = tin;
         ax = axis(rq_ff.grid_x_segments, r_ff, rq_ff.tile_x, qa_ff, ra_ff);
         if (tin) begin
            res_in.x_first_node  = ax[3*NW +: SW];
            res_in.x_last_node   = ax[2*NW +: SW];
            res_in.x_nodes_total = ax[2*NW-1 -: NW];
            res_in.x_nodes_owned = ax[NW-1:0];
         end
      end
      if (cmd.take_b && res_ff.tile_valid) begin
         ax = axis(rq_ff.grid_y_segments, c_ff, rq_ff.tile_y, quo, rem);
         res_in.y_first_node  = ax[3*NW +: SW];
         res_in.y_last_node   = ax[2*NW +: SW];
         res_in.y_nodes_total = ax[2*NW-1 -: NW];
         res_in.y_nodes_owned = ax[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.load) begin
         rq_ff <= req_word; t_ff <= PW'(1); swap_ff <= 1'b0;
      end
      if (cmd.next_t) t_ff <= t_ff + PW'(1);
      if (cmd.set_swap) begin swap_ff <= 1'b1; r_ff <= other_ff; c_ff <= t_ff; end
      if (cmd.clr_swap) begin swap_ff <= 1'b0; r_ff <= t_ff; c_ff <= other_ff; end
      if (cmd.take_pt) begin
         other_ff <= quo[PW-1:0]; r_ff <= t_ff; c_ff <= quo[PW-1:0];
         qa_ff <= rem;
      end
      if (cmd.div_op == gbp_pkg::DOP_M_R && div_done) begin
         qa_ff <= quo; ra_ff <= rem;
      end
      if (cmd.div_op == gbp_pkg::DOP_M_Q && div_done) begin
         qa_ff <= quo; ra_ff <= rem;
      end
   end

   assign tt = 26'(t_ff) * 26'(t_ff);
   assign sts.div_done  = div_done;
   assign sts.bad_input = (32'(rq_ff.proc_count) > 32'(MAX_PROCS)) ||
                          (32'(rq_ff.grid_x_segments) > 32'(MAX_SEGMENTS)) ||
                          (32'(rq_ff.grid_y_segments) > 32'(MAX_SEGMENTS));
   assign sts.t_over    = tt > 26'(rq_ff.proc_count);
   assign sts.divides   = (rem == '0);
   assign sts.same      = (other_ff == t_ff);
   assign sts.swapped   = swap_ff;
   assign sts.pair_ok   = (lo_x != '0) && (lo_y != '0) && ((lo_x << 1) >= hi_y) &&
                          (hi_x <= (lo_y << 1));
   assign result        = res_ff;
endmodule

FILE: src/gbp_ctrl.sv
module gbp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   input  gbp_pkg::sts_type sts,
   output gbp_pkg::cmd_type cmd
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_DIVP  = 10'b0000000100,
      S_WAITP = 10'b0000001000,
      S_DIVM  = 10'b0000010000,
      S_WAITM = 10'b0000100000,
      S_DIVN  = 10'b0001000000,
      S_WAITN = 10'b0010000000,
      S_FINB  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type st_ff, st_in;
   logic      fin_ff, fin_in;

   always_comb begin
      st_in = st_ff; fin_in = fin_ff; cmd = '0; cmd.div_op = gbp_pkg::DOP_P_T;
      in_ready = 1'b0; out_valid = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin cmd.load = 1'b1; st_in = S_CHECK; end
         end
         S_CHECK: begin
            fin_in = 1'b0;
            if (sts.bad_input || sts.t_over) begin
               cmd.fail = 1'b1; st_in = S_OUT;
            end else begin
               cmd.div_start = 1'b1; st_in = S_WAITP;
            end
         end
         S_DIVP: begin
            cmd.div_op = gbp_pkg::DOP_M_R; cmd.div_start = 1'b1; st_in = S_WAITM;
         end
         S_WAITP: begin
            if (sts.div_done) begin
               if (sts.divides) begin
                  cmd.take_pt = 1'b1; st_in = S_DIVP;
               end else begin
                  cmd.next_t = 1'b1; st_in = S_CHECK;
               end
            end
         end
         S_DIVM: begin
            cmd.div_op = gbp_pkg::DOP_M_R; cmd.div_start = 1'b1; st_in = S_WAITM;
         end
         S_WAITM: begin
            cmd.div_op = gbp_pkg::DOP_M_R;
            if (sts.div_done) st_in = S_DIVN;
         end
         S_DIVN: begin
            cmd.div_op = gbp_pkg::DOP_N_C; cmd.div_start = 1'b1; st_in = S_WAITN;
         end
         S_WAITN: begin
            cmd.div_op = gbp_pkg::DOP_N_C;
            if (sts.div_done) begin
               if (fin_ff) begin
                  cmd.take_b = 1'b1; cmd.finish = 1'b1; st_in = S_OUT;
               end else if (sts.pair_ok) begin
                  cmd.take_a = 1'b1; fin_in = 1'b1; st_in = S_FINB;
               end else if (!sts.swapped && !sts.same) begin
                  cmd.set_swap = 1'b1; st_in = S_DIVM;
               end else begin
                  cmd.next_t = 1'b1; cmd.clr_swap = sts.swapped; st_in = S_CHECK;
               end
            end
         end
         S_FINB: begin
            cmd.div_op = gbp_pkg::DOP_N_C; cmd.div_start = 1'b1; st_in = S_WAITN;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; fin_ff <= 1'b0;
      end else begin
         st_ff <= st_in; fin_ff <= fin_in;
      end
   end
endmodule

FILE: src/gbp_checker.sv
module gbp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gbp_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req taken while rsp pending");
   a_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tile_valid |-> rsp_data.found)
      else $error("tile valid without split");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second word taken");
endmodule

bind grid_block_partition_planner gbp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
